[src/irpwd_pkg.sv]
// Shared types, constants and the length window check for the IR pulse-width decoder.
// Depends on nothing; every other file of the decoder imports it.
package irpwd_pkg;

  localparam int DEF_WORD_BITS = 16;

  localparam int LEN_W     = 16;
  localparam int COUNT_W   = 5;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd3;

  localparam logic [LEN_W-1:0] RST_HEADER_LEN = 16'd2400;
  localparam logic [LEN_W-1:0] RST_ZERO_LEN   = 16'd600;
  localparam logic [LEN_W-1:0] RST_ONE_LEN    = 16'd1200;
  localparam logic [LEN_W-1:0] RST_TOLERANCE  = 16'd150;

  typedef logic [2:0] evt_class_t;

  // Event classes, in order of precedence.
  localparam evt_class_t CLS_HEADER  = 3'd0;
  localparam evt_class_t CLS_TIMEOUT = 3'd1;
  localparam evt_class_t CLS_ZERO    = 3'd2;
  localparam evt_class_t CLS_ONE     = 3'd3;
  localparam evt_class_t CLS_BAD     = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0] header_len;
    logic [LEN_W-1:0] zero_len;
    logic [LEN_W-1:0] one_len;
    logic [LEN_W-1:0] tolerance;
  } cfg_regs_t;

  // True when |len - target| <= tol.
  function automatic logic len_match(input logic [LEN_W-1:0] len,
                                     input logic [LEN_W-1:0] target,
                                     input logic [LEN_W-1:0] tol);
    logic [LEN_W-1:0] diff;
    diff = (len >= target) ? (len - target) : (target - len);
    return diff <= tol;
  endfunction

endpackage

[src/irpwd_front.sv]
// Front end: accepts pulse events and classifies each against the timing windows.
// Depends on irpwd_pkg.
module irpwd_front import irpwd_pkg::*; (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [LEN_W-1:0] pulse_len,
  input  logic             timeout_event,
  input  cfg_regs_t        cfg,
  input  logic             q_full,
  output logic             push,
  output evt_class_t       push_class
);

  logic hdr_hit;
  logic zero_hit;
  logic one_hit;

  assign hdr_hit  = len_match(pulse_len, cfg.header_len, cfg.tolerance);
  assign zero_hit = len_match(pulse_len, cfg.zero_len, cfg.tolerance);
  assign one_hit  = len_match(pulse_len, cfg.one_len, cfg.tolerance);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // The header window wins over everything, then timeout, then zero, then one.
  always_comb begin
    if (hdr_hit) begin
      push_class = CLS_HEADER;
    end else if (timeout_event) begin
      push_class = CLS_TIMEOUT;
    end else if (zero_hit) begin
      push_class = CLS_ZERO;
    end else if (one_hit) begin
      push_class = CLS_ONE;
    end else begin
      push_class = CLS_BAD;
    end
  end

endmodule

[src/irpwd_queue.sv]
// Two-entry queue of classified events between the front and back ends.
// Depends on irpwd_pkg.
module irpwd_queue import irpwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  evt_class_t push_class,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output evt_class_t head_class
);

  evt_class_t  entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_class = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_class;
    end
  end

endmodule

[src/irpwd_back.sv]
// Back end: frame state, bit assembly and the output register.
// Depends on irpwd_pkg.
module irpwd_back import irpwd_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  evt_class_t         head_class,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] bit_count,
  output logic [WORD_W-1:0]  rx_word
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WORD_BITS);

  logic                 frame_open;
  logic                 frame_open_next;
  logic [CNT_W-1:0]     bits_left;
  logic [CNT_W-1:0]     bits_left_next;
  logic [WORD_BITS-1:0] shift_word;
  logic [WORD_BITS-1:0] shift_word_next;
  logic                 emit;
  logic [CNT_W-1:0]     emit_count;
  logic [CNT_W-1:0]     got;
  logic [31:0]          word_ext;

  assign pop = head_valid && (!out_valid || out_ready);
  assign got = FULL_CNT - bits_left;

  always_comb begin
    frame_open_next = frame_open;
    bits_left_next  = bits_left;
    shift_word_next = shift_word;
    emit            = 1'b0;
    emit_count      = got;
    unique case (head_class) inside
      CLS_HEADER: begin
        frame_open_next = 1'b1;
        bits_left_next  = FULL_CNT;
        shift_word_next = '0;
      end
      CLS_TIMEOUT: begin
        if (frame_open) begin
          frame_open_next = 1'b0;
          bits_left_next  = '0;
          emit            = (bits_left != FULL_CNT);
        end
      end
      CLS_ZERO, CLS_ONE: begin
        if (frame_open) begin
          bits_left_next = bits_left - 1'b1;
          // Bits land most significant first, at position bits_left - 1.
          for (int i = 0; i < WORD_BITS; i++) begin
            if ((head_class == CLS_ONE) && (bits_left == CNT_W'(i + 1))) begin
              shift_word_next[i] = 1'b1;
            end
          end
          if (bits_left_next == '0) begin
            frame_open_next = 1'b0;
            emit            = 1'b1;
            emit_count      = FULL_CNT;
          end
        end
      end
      default: begin
        if (frame_open) begin
          frame_open_next = 1'b0;
          bits_left_next  = '0;
        end
      end
    endcase
  end

  assign word_ext = 32'(shift_word_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bits_left  <= '0;
      shift_word <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        frame_open <= frame_open_next;
        bits_left  <= bits_left_next;
        shift_word <= shift_word_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      bit_count <= COUNT_W'(emit_count);
      rx_word   <= word_ext[WORD_W-1:0];
    end
  end

endmodule

[src/ir_pulse_width_decoder.sv]
// IR pulse-width word decoder, top level. Uses irpwd_pkg, irpwd_front, irpwd_queue, irpwd_back.
// Throughput: one event transaction per clock; input stalls only when a held result has filled the two-entry queue.
// Path: the queue registers each accepted event, and the output register takes the result
// when the back end pops the event that finishes it from the queue.
// Reset (rst, synchronous): registers return to their defaults, the frame closes,
// the queue empties and no result is pending.
module ir_pulse_width_decoder import irpwd_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // Event channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LEN_W-1:0]     pulse_len,
  input  logic                 timeout_event,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COUNT_W-1:0]   bit_count,
  output logic [WORD_W-1:0]    rx_word,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  // Configuration registers. Writes are always accepted; software must write them only
  // while the decoder is idle, so the front end sees stable windows; the block does not enforce it.
  cfg_regs_t  cfg;

  logic       push;
  evt_class_t push_class;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  evt_class_t head_class;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_len <= RST_HEADER_LEN;
      cfg.zero_len   <= RST_ZERO_LEN;
      cfg.one_len    <= RST_ONE_LEN;
      cfg.tolerance  <= RST_TOLERANCE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER_LEN: cfg.header_len <= cfg_data;
        REG_ZERO_LEN:   cfg.zero_len   <= cfg_data;
        REG_ONE_LEN:    cfg.one_len    <= cfg_data;
        REG_TOLERANCE:  cfg.tolerance  <= cfg_data;
      endcase
    end
  end

  // The front end compares each mark against the header, zero and one windows and
  // reduces the transaction to a class code. It only stalls when the queue is full.
  irpwd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pulse_len     (pulse_len),
    .timeout_event (timeout_event),
    .cfg           (cfg),
    .q_full        (q_full),
    .push          (push),
    .push_class    (push_class)
  );

  // The queue lets the front keep accepting while a result waits to be taken.
  irpwd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_class (push_class),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_class (head_class)
  );

  // The back end owns the frame state. It takes one class code per cycle whenever
  // the output register is free or being emptied in the same cycle.
  irpwd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_class (head_class),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bit_count  (bit_count),
    .rx_word    (rx_word)
  );

`ifndef SYNTHESIS
  // The front end must never write into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("event pushed into a full queue");

  // The back end only consumes events that are present.
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // A new result only appears right after the back end consumed an event.
  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop))
    else $error("result appeared without a consumed event");
`endif

endmodule

[bench/tb_ir_pulse_width_decoder.sv]
// Self-checking bench for ir_pulse_width_decoder: drives event, result and config channels.
// A scoreboard class predicts each finished frame. Depends on irpwd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_ir_pulse_width_decoder import irpwd_pkg::*; ();

  localparam int WORD_BITS_TB   = DEF_WORD_BITS;
  localparam int RX_HOLD_CYCLES = 400;     // one long receiver stall to back the block up
  localparam int QUIET_CYCLES   = 32;      // lets queued events that emit nothing drain
  localparam int CYCLE_LIMIT    = 600000;

  // How a deliberately shortened frame is ended.
  typedef enum int {END_TIMEOUT, END_BAD, END_HEADER, END_NONE} frame_end_t;

  // The scoreboard keeps its own copy of the registers and the frame state, and a
  // queue of the frames that the decoder still owes on its result channel.
  class irpwd_scoreboard;
    typedef struct {
      logic [COUNT_W-1:0] count;
      logic [WORD_W-1:0]  word;
    } frame_t;

    cfg_regs_t        cfg;
    bit               frame_open;
    logic [4:0]       bits_left;
    logic [WORD_W-1:0] shift_word;
    frame_t           frames_due[$];
    int               errors;

    function new();
      cfg = '{RST_HEADER_LEN, RST_ZERO_LEN, RST_ONE_LEN, RST_TOLERANCE};
      frame_open = 1'b0;
      bits_left  = '0;
      shift_word = '0;
      errors     = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      case (idx)
        REG_HEADER_LEN: cfg.header_len = val;
        REG_ZERO_LEN:   cfg.zero_len   = val;
        REG_ONE_LEN:    cfg.one_len    = val;
        REG_TOLERANCE:  cfg.tolerance  = val;
        default: ;
      endcase
    endfunction

    function bit near(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] target);
      int d;
      d = int'(len) - int'(target);
      if (d < 0) d = -d;
      return d <= int'(cfg.tolerance);
    endfunction

    function void push_frame(input int count);
      frame_t f;
      f.count = COUNT_W'(count);
      f.word  = shift_word;
      frames_due.push_back(f);
    endfunction

    // Applies one accepted event to the predicted frame state.
    function void note_event(input logic [LEN_W-1:0] len, input logic tmo);
      int  got;
      bit  b;
      if (near(len, cfg.header_len)) begin
        frame_open = 1'b1;
        bits_left  = 5'(WORD_BITS_TB);
        shift_word = '0;
        return;
      end
      if (tmo) begin
        if (frame_open) begin
          got = WORD_BITS_TB - int'(bits_left);
          frame_open = 1'b0;
          bits_left  = '0;
          if (got >= 1) push_frame(got);
        end
        return;
      end
      if (!frame_open) return;
      if (near(len, cfg.zero_len)) begin
        b = 1'b0;
      end else if (near(len, cfg.one_len)) begin
        b = 1'b1;
      end else begin
        frame_open = 1'b0;
        bits_left  = '0;
        return;
      end
      bits_left = bits_left - 5'd1;
      shift_word[bits_left] = b;
      if (bits_left == 0) begin
        push_frame(WORD_BITS_TB);
        frame_open = 1'b0;
      end
    endfunction

    function void check_result(input logic [COUNT_W-1:0] count, input logic [WORD_W-1:0] word);
      frame_t f;
      if (frames_due.size() == 0) begin
        $error("unexpected result: bit_count %0d rx_word %h", count, word);
        errors++;
        return;
      end
      f = frames_due.pop_front();
      if (count !== f.count) begin
        $error("bit_count mismatch: expected %0d, actual %0d", f.count, count);
        errors++;
      end
      if (word !== f.word) begin
        $error("rx_word mismatch: expected %h, actual %h", f.word, word);
        errors++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LEN_W-1:0]     pulse_len = '0;
  logic                 timeout_event = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COUNT_W-1:0]   bit_count;
  logic [WORD_W-1:0]    rx_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  irpwd_scoreboard sb = new();

  // Idling controls. The receiver reads rx_idle_on and hold_ask at clock edges, so the
  // main process updates them with nonblocking assignments.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_ask   = 0;
  int items_sent = 0;
  int cycle_cnt  = 0;

  ir_pulse_width_decoder #(.WORD_BITS(WORD_BITS_TB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pulse_len(pulse_len), .timeout_event(timeout_event),
    .out_valid(out_valid), .out_ready(out_ready),
    .bit_count(bit_count), .rx_word(rx_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake or a result that never shows up ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_ir_pulse_width_decoder: errors");
      $finish;
    end
  end

  // Result monitor. Values read right after the edge are the ones the edge sampled.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(bit_count, rx_word);
  end

  // Receiver side. Each pass sets out_ready once and holds it, for a random burst while
  // rx_idle_on is set. A change of hold_ask asks for one long stall, which this process
  // counts out itself while the sender keeps offering events.
  initial begin : rx_side
    int n;
    int seen;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != seen) begin
        seen = hold_ask;
        out_ready <= 1'b0;
        n = RX_HOLD_CYCLES;
      end else if (!rx_idle_on) begin
        out_ready <= 1'b1;
        n = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  // Offers one event transaction and returns at the edge that accepts it, with
  // in_valid still high. The next call either changes the payload in the same step
  // or lowers valid for a gap, so valid never gets two assignments in one step.
  task automatic send_event(input logic [LEN_W-1:0] len, input logic tmo);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    pulse_len     <= len;
    timeout_event <= tmo;
    do @(posedge clk); while (!in_ready);
    sb.note_event(len, tmo);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted frame has come out. It always waits
  // on a clock edge first, so the next transaction starts in a later time step.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The block has to be idle before its registers change: nothing owed, and any
  // queued events that emit nothing have had time to pass through.
  task automatic settle();
    wait_all_results();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_regs_t s);
    logic [CFG_IDX_W-1:0] idxs [4];
    logic [LEN_W-1:0]     vals [4];
    idxs = '{REG_HEADER_LEN, REG_ZERO_LEN, REG_ONE_LEN, REG_TOLERANCE};
    vals = '{s.header_len, s.zero_len, s.one_len, s.tolerance};
    foreach (idxs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // A length inside the window around target, often right on one of its edges.
  function automatic logic [LEN_W-1:0] len_near(input logic [LEN_W-1:0] target);
    int lo;
    int hi;
    lo = int'(target) - int'(sb.cfg.tolerance);
    hi = int'(target) + int'(sb.cfg.tolerance);
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 5))
      0: return LEN_W'(lo);
      1: return LEN_W'(hi);
      default: return LEN_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // A length just outside the window around target, where there is room for one.
  function automatic logic [LEN_W-1:0] len_off(input logic [LEN_W-1:0] target);
    int up;
    int dn;
    up = int'(target) + int'(sb.cfg.tolerance) + 1;
    dn = int'(target) - int'(sb.cfg.tolerance) - 1;
    if (up <= 65535 && (dn < 0 || $urandom_range(0, 1) == 1)) return LEN_W'(up);
    if (dn >= 0) return LEN_W'(dn);
    return LEN_W'($urandom);
  endfunction

  // A header followed by nbits data marks. A frame shorter than a full word is ended
  // the way how asks; a full word closes by itself.
  task automatic send_frame(input int nbits, input frame_end_t how);
    bit b;
    send_event(len_near(sb.cfg.header_len), $urandom_range(0, 3) == 0);
    for (int i = 0; i < nbits; i++) begin
      b = $urandom_range(0, 1);
      send_event(len_near(b ? sb.cfg.one_len : sb.cfg.zero_len), 1'b0);
    end
    if (nbits < WORD_BITS_TB) begin
      case (how)
        END_TIMEOUT: send_event(LEN_W'($urandom), 1'b1);
        END_BAD:     send_event(len_off($urandom_range(0, 1) ? sb.cfg.zero_len
                                                             : sb.cfg.one_len), 1'b0);
        default: ;   // the next header, or whatever comes next, cuts the frame
      endcase
    end
  endtask

  // Mostly well-formed frames with random content, some broken frames, some noise.
  task automatic random_phase(input int n_items, input bit allow_idle);
    int start;
    int pick;
    int nb;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (allow_idle && $urandom_range(0, 15) == 0) tx_idle_on = ~tx_idle_on;
      if (allow_idle && $urandom_range(0, 15) == 0) rx_idle_on <= ~rx_idle_on;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        nb = $urandom_range(0, 1) ? WORD_BITS_TB : $urandom_range(1, WORD_BITS_TB - 1);
        send_frame(nb, END_TIMEOUT);
      end else if (pick == 7) begin
        send_frame($urandom_range(0, WORD_BITS_TB - 1), frame_end_t'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 4)) send_event(LEN_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // Hand-picked events against the reset register values (header 2400, zero 600,
  // one 1200, tolerance 150).
  task automatic directed_checks();
    send_event(16'd600, 1'b0);     // a data mark with no frame open is ignored
    send_event(16'd65535, 1'b1);   // a timeout with no frame open closes silently
    send_event(16'd2400, 1'b0);    // header opens a frame
    send_event(16'd0, 1'b1);       // timeout before any bit: closes with no result
    send_event(16'd2550, 1'b1);    // header at the upper window edge wins over the timeout
    send_event(16'd450, 1'b0);     // zero at the lower edge
    send_event(16'd1350, 1'b0);    // one at the upper edge
    send_event(16'd0, 1'b1);       // timeout after two bits emits a short word
    send_event(16'd2250, 1'b0);    // header at the lower edge
    send_event(16'd601, 1'b0);
    send_event(16'd751, 1'b0);     // just outside the zero window: frame drops silently
    send_event(16'd1, 1'b1);       // nothing open any more, so nothing comes out
    send_event(16'd2400, 1'b0);    // a full word of ones
    repeat (WORD_BITS_TB) send_event(16'd1200, 1'b0);
  endtask

  initial begin : main
    cfg_regs_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values first: hand-picked cases, then random traffic. Part way through,
    // the receiver stalls for a long stretch while the sender streams without gaps,
    // and later the sender stops until every owed frame has come out.
    directed_checks();
    random_phase(120, 1'b1);
    tx_idle_on = 1'b0;
    hold_ask <= hold_ask + 1;
    random_phase(80, 1'b0);
    wait_all_results();
    tx_idle_on = 1'b1;
    random_phase(70, 1'b1);

    // Exact matches only, with the header and zero-bit lengths at the ends of their range.
    settle();
    s = '{16'd65535, 16'd0, 16'd32768, 16'd0};
    load_settings(s);
    random_phase(180, 1'b1);

    // Header at zero, zero-bit length at the top, a wide window.
    settle();
    s = '{16'd0, 16'd65535, 16'd21845, 16'd1000};
    load_settings(s);
    random_phase(180, 1'b1);

    // Random lengths in separate bands.
    settle();
    s = '{16'($urandom_range(20000, 65535)), 16'($urandom_range(0, 9000)),
          16'($urandom_range(10000, 19000)), 16'($urandom_range(0, 3000))};
    load_settings(s);
    random_phase(180, 1'b1);

    // Widest tolerance: every length reads as a header, so no frame ever finishes.
    settle();
    s = '{16'($urandom), 16'($urandom), 16'($urandom), 16'd65535};
    load_settings(s);
    random_phase(40, 1'b1);

    // Overlapping windows: header beats one, and zero beats one.
    settle();
    s = '{16'd700, 16'd500, 16'd600, 16'd100};
    load_settings(s);
    random_phase(180, 1'b1);

    // Fully random lengths with a moderate tolerance.
    settle();
    s = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 400))};
    load_settings(s);
    random_phase(150, 1'b1);

    // Reset values written back explicitly; no idling on either side from here on.
    settle();
    s = '{RST_HEADER_LEN, RST_ZERO_LEN, RST_ONE_LEN, RST_TOLERANCE};
    load_settings(s);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    random_phase(150, 1'b0);

    wait_all_results();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_ir_pulse_width_decoder: clean");
    end else begin
      $display("tb_ir_pulse_width_decoder: errors");
    end
    $finish;
  end

endmodule
